@@ rtl/indexed_sequence_list_assert.svh @@
// Assertion macros for the indexed sequence list RTL.
// Used by any module that has clk and arst_n in scope.
`ifndef INDEXED_SEQUENCE_LIST_ASSERT_SVH
`define INDEXED_SEQUENCE_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ISL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ISL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/isl_pkg.sv @@
// Shared constants for the indexed sequence list: capacity, field widths,
// command and status codes. No dependencies.
package isl_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W   = 3;
	localparam int POS_W   = 16;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_HEAD  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_TAIL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_INDEX = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	localparam logic [VAL_W-1:0] NOT_FOUND = '1;

endpackage

@@ rtl/isl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/indexed_sequence_list.sv @@
// Rejects and a tail delete finish in DECIDE; a get passes through GETRD, an insert
// at the end through WRITE, an insert that moves entries through SHIFT, DRAIN and
// WRITE, a delete that moves entries through SHIFT and DRAIN. Busy holds off requests
// meanwhile, and a new request is taken in the cycle done shows. One entry moves
// per cycle through the single RAM port pair. Receiver cannot stall. Reset (arst_n low,
// asynchronous) empties the list. Uses isl_pkg, isl_ram, the assertion macros.
`include "indexed_sequence_list_assert.svh"

module indexed_sequence_list import isl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   value,
	output logic               done,
	output logic [VAL_W-1:0]   read_value,
	output logic [STAT_W-1:0]  status,
	output logic [COUNT_W-1:0] count
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_GETRD  = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_WRITE  = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CMD_W-1:0]    cmd_q;
	logic [POS_W-1:0]    pos_q;
	logic [VAL_W-1:0]    val_q;
	logic [ADDR_W-1:0]   p_q, p_d;
	logic [ADDR_W-1:0]   idx_q, idx_d;
	logic                rd_vld_q;
	logic [ADDR_W-1:0]   rd_src_q;
	logic [LEN_W-1:0]    len_q, len_d;
	logic                done_q, done_d;
	logic [VAL_W-1:0]    read_value_q, read_value_d;
	logic [STAT_W-1:0]   status_q, status_d;
	logic [COUNT_W-1:0]  count_q;

	logic [POS_W-1:0]    len16;
	logic [POS_W-1:0]    pe16;
	logic [ADDR_W-1:0]   last_src;
	logic                is_del;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [VAL_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [VAL_W-1:0]    ram_rdata;

	assign busy   = (state_q != S_IDLE);
	assign len16  = POS_W'(len_q);
	assign is_del = (cmd_q == CMD_DELETE);
	// len-1 as an address; only used while the list is non-empty
	assign last_src = ADDR_W'(len_q - LEN_W'(1));

	// effective insert position
	always_comb begin
		case (cmd_q)
			CMD_ADD_HEAD: pe16 = '0;
			CMD_ADD_TAIL: pe16 = len16;
			default:      pe16 = pos_q;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		p_d          = p_q;
		idx_d        = idx_q;
		len_d        = len_q;
		done_d       = 1'b0;
		read_value_d = NOT_FOUND;
		status_d     = STAT_RANGE;
		ram_raddr    = idx_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (cmd_q)
					CMD_GET: begin
						ram_raddr = pos_q[ADDR_W-1:0];
						if (pos_q < len16) begin
							state_d = S_GETRD;
						end else begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end
					CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_ADD_INDEX: begin
						p_d = pe16[ADDR_W-1:0];
						if (pe16 > len16) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else if (len_q == LEN_W'(CAPACITY)) begin
							status_d = STAT_FULL;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else if (pe16 == len16) begin
							state_d = S_WRITE;
						end else begin
							// move entries up, starting from the top
							idx_d   = last_src;
							state_d = S_SHIFT;
						end
					end
					CMD_DELETE: begin
						if (pos_q < len16) begin
							if ((17'(pos_q) + 17'd1) == 17'(len_q)) begin
								// deleting the tail element moves nothing
								len_d    = len_q - LEN_W'(1);
								status_d = STAT_DONE;
								done_d   = 1'b1;
								state_d  = S_IDLE;
							end else begin
								idx_d   = ADDR_W'(pos_q[ADDR_W-1:0] + ADDR_W'(1));
								state_d = S_SHIFT;
							end
						end else begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_GETRD: begin
				read_value_d = ram_rdata;
				status_d     = STAT_DONE;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			S_SHIFT: begin
				ram_raddr = idx_q;
				if (is_del) begin
					if (idx_q == last_src) begin
						state_d = S_DRAIN;
					end else begin
						idx_d = idx_q + ADDR_W'(1);
					end
				end else begin
					if (idx_q == p_q) begin
						state_d = S_DRAIN;
					end else begin
						idx_d = idx_q - ADDR_W'(1);
					end
				end
			end
			S_DRAIN: begin
				// last moved entry is written this cycle
				if (is_del) begin
					len_d    = len_q - LEN_W'(1);
					status_d = STAT_DONE;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				len_d    = len_q + LEN_W'(1);
				status_d = STAT_DONE;
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// a read issued in SHIFT lands in the next cycle and is written one slot over
	assign ram_we    = rd_vld_q || (state_q == S_WRITE);
	assign ram_wdata = (state_q == S_WRITE) ? val_q : ram_rdata;
	always_comb begin
		if (state_q == S_WRITE) begin
			ram_waddr = p_q;
		end else if (is_del) begin
			ram_waddr = rd_src_q - ADDR_W'(1);
		end else begin
			ram_waddr = rd_src_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			len_q    <= len_d;
			done_q   <= done_d;
			rd_vld_q <= (state_q == S_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= value;
		end
		p_q      <= p_d;
		idx_q    <= idx_d;
		rd_src_q <= idx_q;
		if (done_d) begin
			read_value_q <= read_value_d;
			status_q     <= status_d;
			count_q      <= COUNT_W'(len_d);
		end
	end

	isl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;

	`ISL_ASSERT_SAME(a_len_bound, 1'b1, len_q <= LEN_W'(CAPACITY), "list length above capacity")
	`ISL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
	`ISL_ASSERT_SAME(a_fail_value, done && status != STAT_DONE, read_value == NOT_FOUND, "failed request returned a value")
	`ISL_ASSERT_NEXT(a_shift_exit, state_q == S_SHIFT, state_q == S_SHIFT || state_q == S_DRAIN, "shift left without drain")
	`ISL_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")

endmodule
